// File: sv/qfs_pkg.sv
`timescale 1ns / 1ps
package qfs_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DELIM_CHARS = 2'd0;
  localparam logic [1:0] REG_DELIM_COUNT = 2'd1;
  localparam logic [1:0] REG_QUOTE_CHARS = 2'd2;
  localparam logic [1:0] REG_QUOTE_COUNT = 2'd3;

  localparam int unsigned NumDelims = 4;
  localparam int unsigned NumQuotes = 2;

  localparam logic [31:0] DelimCharsRst = 32'd44;
  localparam logic [2:0]  DelimCountRst = 3'd1;
  localparam logic [15:0] QuoteCharsRst = 16'd34;
  localparam logic [1:0]  QuoteCountRst = 2'd1;

  // result kinds
  localparam logic [1:0] OUT_CHAR  = 2'd0;
  localparam logic [1:0] OUT_END   = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_AFTER_QUOTE = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED    = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY    = 2'd2;

  localparam logic [7:0] NulChar = 8'd0;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_AFTERQ,
    MODE_ERROR
  } mode_e;

  typedef struct packed {
    logic [31:0] delim_chars;
    logic [2:0]  delim_count;
    logic [15:0] quote_chars;
    logic [1:0]  quote_count;
  } cfg_t;

  typedef struct packed {
    logic is_quote;
    logic is_delim;
    logic is_open;
  } char_class_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] field_index;
    logic [1:0] error_code;
    logic       final_res;
  } result_t;

  typedef struct packed {
    mode_e mode;
    logic  field_zero;
  } parse_status_t;

endpackage

// File: sv/qfs_in_if.sv
`timescale 1ns / 1ps
interface qfs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

// File: sv/qfs_out_if.sv
`timescale 1ns / 1ps
interface qfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [7:0] field_index;
  logic [1:0] error_code;
  logic       final_res;

  modport source (
    output valid, output out_kind, output out_byte, output field_index,
    output error_code, output final_res, input ready
  );
  modport sink (
    input valid, input out_kind, input out_byte, input field_index,
    input error_code, input final_res, output ready
  );
endinterface

// File: sv/quoted_field_splitter.sv
`timescale 1ns / 1ps
// quoted field splitter
// in_i carries one text character (kind 0) or the end of text (kind 1) per
// request; out_o returns at most one result per request: a kept field
// character, a field end, or an error with its code. field_index tells which
// field a result belongs to and final_res marks the last field end or an error.
// Delimiter and quote sets come from the cfg write port (index 0..3: delimiter
// bytes, delimiter count, quote bytes, quote count); write only while idle.
// A result is registered and appears on out_o in the cycle after its request is accepted.
// One request per cycle while out_o is not stalled; the mode machine and the
// parallel character compares are combinational.
// in_i.ready stays high while the result register is empty or being taken, so
// a stalled receiver holds one result and blocks input only until it is taken.
// Requests that give no result (quote chars, zero bytes, input after an error)
// are still accepted like any other request.
// Reset returns the parser to the start of field 0, drops any pending result
// and restores the default comma delimiter and double quote.
module quoted_field_splitter #(
  parameter int unsigned MAX_FIELDS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qfs_in_if.sink           in_i,
  qfs_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i
);
  import qfs_pkg::*;

  cfg_t          cfg_q;
  result_t       res;
  parse_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_chars <= DelimCharsRst;
      cfg_q.delim_count <= DelimCountRst;
      cfg_q.quote_chars <= QuoteCharsRst;
      cfg_q.quote_count <= QuoteCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELIM_CHARS: cfg_q.delim_chars <= cfg_wdata_i;
        REG_DELIM_COUNT: cfg_q.delim_count <= cfg_wdata_i[2:0];
        REG_QUOTE_CHARS: cfg_q.quote_chars <= cfg_wdata_i[15:0];
        REG_QUOTE_COUNT: cfg_q.quote_count <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  qfs_parser #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .kind_i      (in_i.kind),
    .char_i      (in_i.char_code),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res),
    .status_o    (status)
  );

  assign out_o.out_kind    = res.out_kind;
  assign out_o.out_byte    = res.out_byte;
  assign out_o.field_index = res.field_index;
  assign out_o.error_code  = res.error_code;
  assign out_o.final_res   = res.final_res;

  // end of text always restarts at field zero
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.kind
    |=> status.mode == MODE_START && status.field_zero)
    else $error("end of text did not restart the parser");

  // an error result is always final; all but the unclosed-quote error leave the parser in error mode
  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) && out_o.out_kind == OUT_ERROR && out_o.error_code != ERR_UNCLOSED
    |-> out_o.final_res && (status.mode == MODE_ERROR || status.field_zero))
    else $error("error result not final");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule

// File: sv/qfs_classifier.sv
`timescale 1ns / 1ps
module qfs_classifier (
  input  qfs_pkg::cfg_t        cfg_i,
  input  logic [7:0]           char_i,
  input  logic [7:0]           open_quote_i,
  output qfs_pkg::char_class_t class_o
);
  import qfs_pkg::*;

  logic [NumDelims-1:0] delim_hit;
  logic [NumQuotes-1:0] quote_hit;

  // counts above range simply enable every slot
  always_comb begin
    for (int i = 0; i < NumDelims; i++) begin
      delim_hit[i] = (32'(cfg_i.delim_count) > 32'(i))
                     && (cfg_i.delim_chars[8*i +: 8] == char_i);
    end
    for (int i = 0; i < NumQuotes; i++) begin
      quote_hit[i] = (32'(cfg_i.quote_count) > 32'(i))
                     && (cfg_i.quote_chars[8*i +: 8] == char_i);
    end
  end

  assign class_o.is_delim = |delim_hit;
  assign class_o.is_quote = |quote_hit;
  assign class_o.is_open  = (char_i == open_quote_i);

endmodule

// File: sv/qfs_parser.sv
`timescale 1ns / 1ps
module qfs_parser #(
  parameter int unsigned MAX_FIELDS = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qfs_pkg::cfg_t           cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [7:0]              char_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output qfs_pkg::result_t        res_o,
  output qfs_pkg::parse_status_t  status_o
);
  import qfs_pkg::*;

  localparam int unsigned FieldW = $clog2(MAX_FIELDS);
  localparam logic [FieldW-1:0] LastField = FieldW'(MAX_FIELDS - 1);

  mode_e             mode_q, mode_d;
  logic [7:0]        open_q, open_d;
  logic [FieldW-1:0] field_q, field_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  logic              res_valid;
  logic              accept;
  char_class_t       cls;

  qfs_classifier u_classifier (
    .cfg_i        (cfg_i),
    .char_i       (char_i),
    .open_quote_i (open_q),
    .class_o      (cls)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d    = mode_q;
    open_d    = open_q;
    field_d   = field_q;
    res_valid = 1'b0;
    res_d.out_kind    = OUT_CHAR;
    res_d.out_byte    = NulChar;
    res_d.field_index = 8'(field_q);
    res_d.error_code  = ERR_AFTER_QUOTE;
    res_d.final_res   = 1'b0;

    if (accept) begin
      if (kind_i) begin
        // end of text always returns to the start state
        mode_d  = MODE_START;
        open_d  = NulChar;
        field_d = '0;
        if (mode_q == MODE_QUOTED) begin
          res_valid        = 1'b1;
          res_d.out_kind   = OUT_ERROR;
          res_d.error_code = ERR_UNCLOSED;
          res_d.final_res  = 1'b1;
        end else if (mode_q != MODE_ERROR) begin
          res_valid       = 1'b1;
          res_d.out_kind  = OUT_END;
          res_d.final_res = 1'b1;
        end
      end else if (char_i != NulChar && mode_q != MODE_ERROR) begin
        res_valid = 1'b1;
        unique case (mode_q)
          MODE_START: begin
            if (cls.is_quote) begin
              res_valid = 1'b0;
              open_d    = char_i;
              mode_d    = MODE_QUOTED;
            end else if (!cls.is_delim) begin
              mode_d         = MODE_PLAIN;
              res_d.out_byte = char_i;
            end
          end
          MODE_PLAIN: begin
            if (!cls.is_delim) begin
              res_d.out_byte = char_i;
            end
          end
          MODE_QUOTED: begin
            if (cls.is_open) begin
              res_valid = 1'b0;
              mode_d    = MODE_AFTERQ;
            end else begin
              res_d.out_byte = char_i;
            end
          end
          MODE_AFTERQ: begin
            if (cls.is_open) begin
              mode_d         = MODE_QUOTED;
              res_d.out_byte = char_i;
            end else if (!cls.is_delim) begin
              mode_d           = MODE_ERROR;
              res_d.out_kind   = OUT_ERROR;
              res_d.error_code = ERR_AFTER_QUOTE;
              res_d.final_res  = 1'b1;
            end
          end
          default: begin
            res_valid = 1'b0;
            mode_d    = MODE_ERROR;
          end
        endcase

        // delimiter closes the field, unless the field count would overflow
        if (res_valid && cls.is_delim && mode_d == mode_q && !cls.is_open
            && mode_q != MODE_QUOTED && !(mode_q == MODE_START && cls.is_quote)) begin
          if (field_q == LastField) begin
            mode_d           = MODE_ERROR;
            res_d.out_kind   = OUT_ERROR;
            res_d.error_code = ERR_TOO_MANY;
            res_d.final_res  = 1'b1;
          end else begin
            res_d.out_kind = OUT_END;
            field_d        = field_q + 1'b1;
            mode_d         = MODE_START;
            open_d         = NulChar;
          end
        end
      end
    end

    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_START;
      open_q      <= NulChar;
      field_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      open_q      <= open_d;
      field_q     <= field_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign res_o               = res_q;
  assign status_o.mode       = mode_q;
  assign status_o.field_zero = (field_q == '0);

endmodule
